### rtl/core/lcd4_pkg.sv
// types and constants shared by the 4-bit character display driver
// no dependencies; imported by lcd4_cfg, lcd4_seq, char_lcd_4bit_interface_core and both testbench files
package lcd4_pkg;

  localparam int unsigned WaitW = 16;
  localparam int unsigned CfgIdxW = 2;

  typedef enum logic [1:0] {
    KIND_TICK = 2'd0,
    KIND_CMD  = 2'd1,
    KIND_DATA = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_PWR_WAIT = 2'd0,
    CFG_SECOND_WAIT = 2'd1,
    CFG_THIRD_WAIT = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    PH_PWR  = 5'd0,
    PH_N1A  = 5'd1,
    PH_N1B  = 5'd2,
    PH_W2   = 5'd3,
    PH_N2A  = 5'd4,
    PH_N2B  = 5'd5,
    PH_W3   = 5'd6,
    PH_N3A  = 5'd7,
    PH_N3B  = 5'd8,
    PH_G1   = 5'd9,
    PH_G2   = 5'd10,
    PH_N4A  = 5'd11,
    PH_N4B  = 5'd12,
    PH_B0   = 5'd13,
    PH_B1   = 5'd14,
    PH_B2   = 5'd15,
    PH_B3   = 5'd16,
    PH_S    = 5'd17,
    PH_H    = 5'd18,
    PH_L0   = 5'd19,
    PH_LH   = 5'd20,
    PH_END  = 5'd21,
    PH_IDLE = 5'd22
  } phase_e;

  localparam logic [2:0] InitCmdCount = 3'd4;
  localparam logic [3:0] NibInit = 4'h3;
  localparam logic [3:0] NibFourBit = 4'h2;
  localparam logic [WaitW-1:0] PwrWaitRst = 16'd30000;
  localparam logic [WaitW-1:0] SecondWaitRst = 16'd10000;
  localparam logic [WaitW-1:0] ThirdWaitRst = 16'd150;

  typedef struct packed {
    logic [WaitW-1:0] pwr_wait;
    logic [WaitW-1:0] second_wait;
    logic [WaitW-1:0] third_wait;
  } lcd4_cfg_t;

  typedef struct packed {
    logic       accepted;
    logic       ready_res;
    logic       drive_bus;
    logic [3:0] nibble_out;
    logic       enable_pin;
    logic       read_write;
    logic       reg_select;
  } lcd4_res_t;

  function automatic logic [7:0] init_cmd(input logic [1:0] step);
    logic [7:0] cmd;
    case (step)
      2'd0: cmd = 8'h20;
      2'd1: cmd = 8'h0C;
      2'd2: cmd = 8'h01;
      2'd3: cmd = 8'h06;
      default: cmd = 8'h20;
    endcase
    return cmd;
  endfunction

endpackage

### rtl/core/lcd4_cfg.sv
// wait-time configuration registers of the display driver
// depends on lcd4_pkg
module lcd4_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         wr_en_i,
  input  logic [lcd4_pkg::CfgIdxW-1:0] addr_i,
  input  logic [lcd4_pkg::WaitW-1:0]   wdata_i,
  output lcd4_pkg::lcd4_cfg_t          cfg_o
);
  import lcd4_pkg::*;

  lcd4_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pwr_wait    <= PwrWaitRst;
      cfg_q.second_wait <= SecondWaitRst;
      cfg_q.third_wait  <= ThirdWaitRst;
    end else if (wr_en_i) begin
      case (cfg_idx_e'(addr_i))
        CFG_PWR_WAIT:    cfg_q.pwr_wait <= wdata_i;
        CFG_SECOND_WAIT: cfg_q.second_wait <= wdata_i;
        CFG_THIRD_WAIT:  cfg_q.third_wait <= wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/core/lcd4_seq.sv
// pin sequencer: phase state machine, wait counter and held byte
// depends on lcd4_pkg; one step per registered tick
module lcd4_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [1:0]          kind_i,
  input  logic [7:0]          byte_i,
  input  logic [3:0]          pins_i,
  input  lcd4_pkg::lcd4_cfg_t cfg_i,
  output lcd4_pkg::lcd4_res_t res_o
);
  import lcd4_pkg::*;

  phase_e            phase_q, phase_d, ph;
  logic [WaitW-1:0]  wait_q, wait_d, wc;
  logic [7:0]        byte_q, byte_d;
  logic              rs_q, rs_d;
  logic [2:0]        init_q, init_d;
  logic              busy_q, busy_d;
  lcd4_res_t         res;
  logic              req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PWR;
      wait_q  <= '0;
      byte_q  <= '0;
      rs_q    <= 1'b0;
      init_q  <= '0;
      busy_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      wait_q  <= wait_d;
      byte_q  <= byte_d;
      rs_q    <= rs_d;
      init_q  <= init_d;
      busy_q  <= busy_d;
    end
  end

  assign req = (kind_i == KIND_CMD) || (kind_i == KIND_DATA);

  always_comb begin
    ph = phase_q;
    wc = wait_q;
    // finished wait hands over to its strobe in the same tick
    if (phase_q == PH_PWR && wait_q >= cfg_i.pwr_wait) begin
      ph = PH_N1A;
      wc = '0;
    end else if (phase_q == PH_W2 && wait_q >= cfg_i.second_wait) begin
      ph = PH_N2A;
      wc = '0;
    end else if (phase_q == PH_W3 && wait_q >= cfg_i.third_wait) begin
      ph = PH_N3A;
      wc = '0;
    end

    phase_d = ph;
    wait_d  = wc;
    byte_d  = byte_q;
    rs_d    = rs_q;
    init_d  = init_q;
    busy_d  = busy_q;
    res     = '{accepted: 1'b0, ready_res: 1'b0, drive_bus: 1'b1, nibble_out: 4'h0,
                enable_pin: 1'b0, read_write: 1'b0, reg_select: 1'b0};

    case (ph)
      PH_PWR: wait_d = wc + 1'b1;
      PH_N1A: begin
        res.enable_pin = 1'b1; res.nibble_out = NibInit; phase_d = PH_N1B;
      end
      PH_N1B: begin
        res.enable_pin = 1'b1; res.nibble_out = NibInit; phase_d = PH_W2; wait_d = '0;
      end
      PH_W2: begin
        res.nibble_out = NibInit; wait_d = wc + 1'b1;
      end
      PH_N2A: begin
        res.enable_pin = 1'b1; res.nibble_out = NibInit; phase_d = PH_N2B;
      end
      PH_N2B: begin
        res.enable_pin = 1'b1; res.nibble_out = NibInit; phase_d = PH_W3; wait_d = '0;
      end
      PH_W3: begin
        res.nibble_out = NibInit; wait_d = wc + 1'b1;
      end
      PH_N3A: begin
        res.enable_pin = 1'b1; res.nibble_out = NibInit; phase_d = PH_N3B;
      end
      PH_N3B: begin
        res.enable_pin = 1'b1; res.nibble_out = NibInit; phase_d = PH_G1;
      end
      PH_G1: begin
        res.nibble_out = NibInit; phase_d = PH_G2;
      end
      PH_G2: begin
        res.nibble_out = NibInit; phase_d = PH_N4A;
      end
      PH_N4A: begin
        res.enable_pin = 1'b1; res.nibble_out = NibFourBit; phase_d = PH_N4B;
      end
      PH_N4B: begin
        res.enable_pin = 1'b1; res.nibble_out = NibFourBit; phase_d = PH_END;
      end
      PH_B0: begin
        res.read_write = 1'b1; res.drive_bus = 1'b0; res.enable_pin = 1'b1;
        busy_d = pins_i[3];
        phase_d = PH_B1;
      end
      PH_B1: begin
        res.read_write = 1'b1; res.drive_bus = 1'b0; phase_d = PH_B2;
      end
      PH_B2: begin
        res.read_write = 1'b1; res.drive_bus = 1'b0; res.enable_pin = 1'b1;
        phase_d = PH_B3;
      end
      PH_B3: begin
        res.read_write = 1'b1; res.drive_bus = 1'b0;
        phase_d = busy_q ? PH_B0 : PH_S;
      end
      PH_S: begin
        res.reg_select = rs_q; res.nibble_out = byte_q[7:4]; phase_d = PH_H;
      end
      PH_H: begin
        res.reg_select = rs_q; res.enable_pin = 1'b1; res.nibble_out = byte_q[7:4];
        phase_d = PH_L0;
      end
      PH_L0: begin
        res.reg_select = rs_q; res.nibble_out = byte_q[3:0]; phase_d = PH_LH;
      end
      PH_LH: begin
        res.reg_select = rs_q; res.enable_pin = 1'b1; res.nibble_out = byte_q[3:0];
        phase_d = PH_END;
      end
      PH_END: begin
        res.reg_select = rs_q; res.nibble_out = byte_q[3:0];
        if (init_q < InitCmdCount) begin
          byte_d  = init_cmd(init_q[1:0]);
          rs_d    = 1'b0;
          init_d  = init_q + 1'b1;
          phase_d = PH_B0;
        end else begin
          phase_d = PH_IDLE;
        end
      end
      PH_IDLE: begin
        res.reg_select = rs_q; res.nibble_out = byte_q[3:0]; res.ready_res = 1'b1;
        if (req) begin
          byte_d       = byte_i;
          rs_d         = (kind_i == KIND_DATA);
          res.accepted = 1'b1;
          phase_d      = PH_B0;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  assign res_o = res;

endmodule

### rtl/core/char_lcd_4bit_interface_core.sv
// 4-bit character display driver, top level with input and result registers
// depends on lcd4_pkg, lcd4_cfg and lcd4_seq
//
// usage:
//   each request on the s_axis channel is one microsecond tick; tuser holds
//   the kind (tick only, command byte, data byte), tdata the byte and the
//   sampled D4-D7 pins. every request yields exactly one result on m_axis
//   with the pin levels to drive during that tick plus ready and accepted.
//   after reset the power-up nibble sequence and the four init commands run
//   from ticks alone; byte requests made before the block is ready are refused.
//   wait times are set through the cfg write port while no request is in flight.
// timing:
//   a request passes an input register, then one step of the sequencer into
//   the result register; one request per cycle is sustained while m_axis
//   does not stall.
// reset clears the sequencer and both valid flags and reloads the wait
// registers with their default values.
// a stalled m_axis holds the result; s_axis keeps taking requests until both
// the input and result registers are full, then deasserts tready.
module char_lcd_4bit_interface_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,  // byte_value, pin_nibble, pad
  input  logic [1:0]                   s_axis_tuser,  // kind
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // reg_select, read_write, enable_pin, nibble_out, drive_bus, ready_res, accepted, pad
  output logic [15:0]                  m_axis_tdata,
  input  logic                         cfg_wr_en_i,
  input  logic [lcd4_pkg::CfgIdxW-1:0] cfg_addr_i,
  input  logic [lcd4_pkg::WaitW-1:0]   cfg_wdata_i
);
  import lcd4_pkg::*;

  logic       in_valid_q;
  logic [1:0] kind_q;
  logic [7:0] byte_q;
  logic [3:0] pins_q;
  logic       out_valid_q;
  lcd4_res_t  res_q;
  lcd4_res_t  res;
  lcd4_cfg_t  cfg;
  logic       advance;
  logic       step;

  assign advance = !out_valid_q || m_axis_tready;
  assign step = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q <= s_axis_tuser;
      byte_q <= s_axis_tdata[7:0];
      pins_q <= s_axis_tdata[11:8];
    end
    if (step) begin
      res_q <= res;
    end
  end

  lcd4_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_en_i (cfg_wr_en_i),
    .addr_i  (cfg_addr_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  lcd4_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .kind_i (kind_q),
    .byte_i (byte_q),
    .pins_i (pins_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = {6'b0, res_q.accepted, res_q.ready_res, res_q.drive_bus,
                         res_q.nibble_out, res_q.enable_pin, res_q.read_write,
                         res_q.reg_select};

endmodule

### tb/lcd4_pin_checker.sv
`timescale 1ns / 1ps
// checker for the 4-bit character display driver: predicts the pin levels of every tick
// and compares them with the result channel; depends on lcd4_pkg
module lcd4_pin_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [15:0] s_tdata_i,   // byte_value, pin_nibble, pad
  input  logic [1:0]  s_tuser_i,   // kind
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // reg_select, read_write, enable_pin, nibble_out, drive_bus, ready_res, accepted, pad
  input  logic [15:0] m_tdata_i,
  input  logic        cfg_wr_en_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  output int unsigned mismatch_cnt_o,
  output int unsigned pending_o
);
  import lcd4_pkg::*;

  localparam logic [7:0] CmdFuncSet   = 8'h20;
  localparam logic [7:0] CmdDisplayOn = 8'h0C;
  localparam logic [7:0] CmdClear     = 8'h01;
  localparam logic [7:0] CmdEntryMode = 8'h06;

  logic [15:0] pwr_wait_q, second_wait_q, third_wait_q;
  phase_e      seq_phase;
  logic [15:0] wait_cnt;
  logic [7:0]  held_byte;
  logic        held_rs;
  logic [2:0]  boot_cmds_sent;
  logic        busy_seen;

  lcd4_res_t   pin_levels_q[$];
  lcd4_res_t   want, got;
  int unsigned mismatch_cnt = 0;

  assign mismatch_cnt_o = mismatch_cnt;

  task automatic advance_pin_sequencer(input logic [1:0] kind, input logic [7:0] bval,
                                       input logic [3:0] pins, output lcd4_res_t lv);
    phase_e nxt;
    lv = '0;
    lv.drive_bus = 1'b1;
    // an expired wait hands over to its strobe within the same tick
    if (seq_phase == PH_PWR && wait_cnt >= pwr_wait_q) begin
      seq_phase = PH_N1A;
      wait_cnt = '0;
    end else if (seq_phase == PH_W2 && wait_cnt >= second_wait_q) begin
      seq_phase = PH_N2A;
      wait_cnt = '0;
    end else if (seq_phase == PH_W3 && wait_cnt >= third_wait_q) begin
      seq_phase = PH_N3A;
      wait_cnt = '0;
    end
    nxt = seq_phase;
    case (seq_phase)
      PH_PWR: wait_cnt = wait_cnt + 1'b1;
      PH_N1A: begin
        lv.enable_pin = 1'b1; lv.nibble_out = NibInit; nxt = PH_N1B;
      end
      PH_N1B: begin
        lv.enable_pin = 1'b1; lv.nibble_out = NibInit; nxt = PH_W2; wait_cnt = '0;
      end
      PH_W2: begin
        lv.nibble_out = NibInit; wait_cnt = wait_cnt + 1'b1;
      end
      PH_N2A: begin
        lv.enable_pin = 1'b1; lv.nibble_out = NibInit; nxt = PH_N2B;
      end
      PH_N2B: begin
        lv.enable_pin = 1'b1; lv.nibble_out = NibInit; nxt = PH_W3; wait_cnt = '0;
      end
      PH_W3: begin
        lv.nibble_out = NibInit; wait_cnt = wait_cnt + 1'b1;
      end
      PH_N3A: begin
        lv.enable_pin = 1'b1; lv.nibble_out = NibInit; nxt = PH_N3B;
      end
      PH_N3B: begin
        lv.enable_pin = 1'b1; lv.nibble_out = NibInit; nxt = PH_G1;
      end
      PH_G1: begin
        lv.nibble_out = NibInit; nxt = PH_G2;
      end
      PH_G2: begin
        lv.nibble_out = NibInit; nxt = PH_N4A;
      end
      PH_N4A: begin
        lv.enable_pin = 1'b1; lv.nibble_out = NibFourBit; nxt = PH_N4B;
      end
      PH_N4B: begin
        lv.enable_pin = 1'b1; lv.nibble_out = NibFourBit; nxt = PH_END;
      end
      PH_B0: begin
        lv.read_write = 1'b1; lv.drive_bus = 1'b0; lv.enable_pin = 1'b1;
        busy_seen = pins[3];
        nxt = PH_B1;
      end
      PH_B1: begin
        lv.read_write = 1'b1; lv.drive_bus = 1'b0; nxt = PH_B2;
      end
      PH_B2: begin
        lv.read_write = 1'b1; lv.drive_bus = 1'b0; lv.enable_pin = 1'b1; nxt = PH_B3;
      end
      PH_B3: begin
        lv.read_write = 1'b1; lv.drive_bus = 1'b0;
        nxt = busy_seen ? PH_B0 : PH_S;
      end
      PH_S: begin
        lv.reg_select = held_rs; lv.nibble_out = held_byte[7:4]; nxt = PH_H;
      end
      PH_H: begin
        lv.reg_select = held_rs; lv.enable_pin = 1'b1; lv.nibble_out = held_byte[7:4];
        nxt = PH_L0;
      end
      PH_L0: begin
        lv.reg_select = held_rs; lv.nibble_out = held_byte[3:0]; nxt = PH_LH;
      end
      PH_LH: begin
        lv.reg_select = held_rs; lv.enable_pin = 1'b1; lv.nibble_out = held_byte[3:0];
        nxt = PH_END;
      end
      PH_END: begin
        lv.reg_select = held_rs; lv.nibble_out = held_byte[3:0];
        if (boot_cmds_sent < InitCmdCount) begin
          case (boot_cmds_sent[1:0])
            2'd0: held_byte = CmdFuncSet;
            2'd1: held_byte = CmdDisplayOn;
            2'd2: held_byte = CmdClear;
            default: held_byte = CmdEntryMode;
          endcase
          held_rs = 1'b0;
          boot_cmds_sent = boot_cmds_sent + 1'b1;
          nxt = PH_B0;
        end else begin
          nxt = PH_IDLE;
        end
      end
      PH_IDLE: begin
        lv.reg_select = held_rs; lv.nibble_out = held_byte[3:0]; lv.ready_res = 1'b1;
        if (kind == KIND_CMD || kind == KIND_DATA) begin
          held_byte = bval;
          held_rs = (kind == KIND_DATA);
          lv.accepted = 1'b1;
          nxt = PH_B0;
        end
      end
      default: nxt = PH_IDLE;
    endcase
    seq_phase = nxt;
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwr_wait_q = PwrWaitRst;
      second_wait_q = SecondWaitRst;
      third_wait_q = ThirdWaitRst;
      seq_phase = PH_PWR;
      wait_cnt = '0;
      held_byte = '0;
      held_rs = 1'b0;
      boot_cmds_sent = '0;
      busy_seen = 1'b0;
      pin_levels_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_wr_en_i) begin
        case (cfg_idx_e'(cfg_addr_i))
          CFG_PWR_WAIT:    pwr_wait_q = cfg_wdata_i;
          CFG_SECOND_WAIT: second_wait_q = cfg_wdata_i;
          CFG_THIRD_WAIT:  third_wait_q = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        advance_pin_sequencer(s_tuser_i, s_tdata_i[7:0], s_tdata_i[11:8], want);
        pin_levels_q.push_back(want);
      end
      if (m_tvalid_i && m_tready_i) begin
        if (pin_levels_q.size() == 0) begin
          $error("result %0h with no request outstanding", m_tdata_i);
          mismatch_cnt++;
        end else begin
          want = pin_levels_q.pop_front();
          got = lcd4_res_t'(m_tdata_i[9:0]);
          check_field("reg_select", want.reg_select, got.reg_select);
          check_field("read_write", want.read_write, got.read_write);
          check_field("enable_pin", want.enable_pin, got.enable_pin);
          check_field("nibble_out", want.nibble_out, got.nibble_out);
          check_field("drive_bus", want.drive_bus, got.drive_bus);
          check_field("ready_res", want.ready_res, got.ready_res);
          check_field("accepted", want.accepted, got.accepted);
          check_field("pad", 0, m_tdata_i[15:10]);
        end
      end
      pending_o <= pin_levels_q.size();
    end
  end

endmodule

### tb/char_lcd_4bit_interface_core_tb.sv
`timescale 1ns / 1ps
// top of the regression for the 4-bit character display driver: clock, reset, request and result traffic,
// wait register writes and the verdict; depends on lcd4_pkg, lcd4_pin_checker and char_lcd_4bit_interface_core
module char_lcd_4bit_interface_core_tb;
  import lcd4_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldOffCycles = 250;
  localparam int unsigned PhaseCount = 5;
  localparam int unsigned RequestsPerPhase = 300;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = KIND_TICK;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_addr = CFG_PWR_WAIT;
  logic [15:0] cfg_wdata = '0;

  int unsigned mismatch_cnt;
  int unsigned pending;
  int unsigned cycle_cnt = 0;
  int unsigned busy_run = 0;
  bit          src_gaps = 1'b1;
  bit          sink_stalls = 1'b1;
  bit          hold_req = 1'b0;

  char_lcd_4bit_interface_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en_i   (cfg_wr_en),
    .cfg_addr_i    (cfg_addr),
    .cfg_wdata_i   (cfg_wdata)
  );

  lcd4_pin_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid),
    .s_tready_i     (s_axis_tready),
    .s_tdata_i      (s_axis_tdata),
    .s_tuser_i      (s_axis_tuser),
    .m_tvalid_i     (m_axis_tvalid),
    .m_tready_i     (m_axis_tready),
    .m_tdata_i      (m_axis_tdata),
    .cfg_wr_en_i    (cfg_wr_en),
    .cfg_addr_i     (cfg_addr),
    .cfg_wdata_i    (cfg_wdata),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("char_lcd_4bit_interface_core regression: fail");
      $finish;
    end
  end

  // result side
  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic send_tick(input logic [1:0] kind, input logic [7:0] bval,
                           input logic [3:0] pins);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'h0, pins, bval};
    s_axis_tuser <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // mostly plain ticks with a sprinkle of byte requests; the busy flag sticks now and then
  task automatic send_random_tick();
    int unsigned pick;
    logic [1:0] kind;
    logic [3:0] pins;
    pick = $urandom_range(0, 19);
    if (pick < 12) kind = KIND_TICK;
    else if (pick < 15) kind = KIND_CMD;
    else if (pick < 18) kind = KIND_DATA;
    else kind = 2'd3;
    pins = 4'($urandom_range(0, 15));
    if (busy_run == 0 && $urandom_range(0, 59) == 0) busy_run = $urandom_range(4, 16);
    if (busy_run != 0) begin
      pins[3] = 1'b1;
      busy_run--;
    end else begin
      pins[3] = ($urandom_range(0, 9) == 0);
    end
    send_tick(kind, 8'($urandom_range(0, 255)), pins);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_wait_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    cfg_wr_en <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] wait_val;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_wait_reg(CFG_PWR_WAIT, 16'hFFFF);
    write_wait_reg(CFG_SECOND_WAIT, 16'hFFFF);
    write_wait_reg(CFG_THIRD_WAIT, 16'hFFFF);

    // byte requests during power-up are refused
    send_tick(KIND_TICK, 8'h00, 4'h0);
    send_tick(KIND_CMD, 8'hFF, 4'hF);
    send_tick(KIND_DATA, 8'h00, 4'h8);
    send_tick(2'd3, 8'hA5, 4'h7);
    send_tick(KIND_DATA, 8'hFF, 4'hF);
    send_tick(KIND_CMD, 8'h00, 4'h0);
    send_tick(KIND_TICK, 8'h5A, 4'h1);
    send_tick(KIND_TICK, 8'hC3, 4'h2);
    send_tick(KIND_TICK, 8'h3C, 4'h4);
    send_tick(KIND_TICK, 8'hFF, 4'h8);
    send_tick(2'd3, 8'h5A, 4'hF);
    send_tick(KIND_TICK, 8'h00, 4'hF);

    // lowered power-up wait ends at once, zero second wait takes no tick
    wait_drained();
    write_wait_reg(CFG_PWR_WAIT, 16'd5);
    write_wait_reg(CFG_SECOND_WAIT, 16'd0);
    repeat (20) send_random_tick();
    wait_drained();
    write_wait_reg(CFG_THIRD_WAIT, 16'd3);

    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      if (ph == 1) hold_req = 1'b1;
      if (ph == PhaseCount - 1) begin
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
      end
      repeat (RequestsPerPhase) send_random_tick();
      wait_drained();
      if (ph == 0) wait_val = 16'h0000;
      else if (ph == 1) wait_val = 16'hFFFF;
      else wait_val = 16'($urandom_range(0, 65535));
      write_wait_reg(CFG_PWR_WAIT, wait_val);
      write_wait_reg(CFG_SECOND_WAIT, ~wait_val);
      write_wait_reg(CFG_THIRD_WAIT, wait_val);
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("char_lcd_4bit_interface_core regression: pass");
    end else begin
      $display("char_lcd_4bit_interface_core regression: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/lcd4_pkg.sv
rtl/core/lcd4_cfg.sv
rtl/core/lcd4_seq.sv
rtl/core/char_lcd_4bit_interface_core.sv
tb/lcd4_pin_checker.sv
tb/char_lcd_4bit_interface_core_tb.sv
